### sv/fbc64_pkg.sv
// Package: payload types, round constants and round arithmetic for the 64-bit Feistel cipher.
package fbc64_pkg;

   localparam int ROUNDS_DEFAULT = 8;
   localparam int ROUNDS_MAX     = 8;
   localparam int WORD_W         = 32;
   localparam int ROUND_IDX_W    = 3;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION = 2'd2;

   localparam logic [WORD_W-1:0] GOLDEN = 32'h9E37_79B9;
   localparam logic              DIRECTION_RESET = 1'b1;

   localparam logic [WORD_W-1:0] ROUND_CONST [ROUNDS_MAX] = '{
      32'ha5f1523d, 32'h1b037387, 32'h3c6ef372, 32'hbb67ae85,
      32'h6a09e667, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab
   };

   typedef struct packed {
      logic [WORD_W-1:0] word_left;
      logic [WORD_W-1:0] word_right;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] out_left;
      logic [WORD_W-1:0] out_right;
   } rsp_type;

   // working halves of the block inside the round pipeline
   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
   } block_type;

   typedef struct packed {
      logic [WORD_W-1:0] key;
      logic [WORD_W-1:0] cnst;
   } key_sched_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                              input logic [4:0]        n);
      logic [2*WORD_W-1:0] t;
      t = {x, x} << n;
      return t[2*WORD_W-1:WORD_W];
   endfunction

   function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                              input logic [4:0]        n);
      logic [2*WORD_W-1:0] t;
      t = {x, x} >> n;
      return t[WORD_W-1:0];
   endfunction

   // key word k_j from the 128-bit key {K3, K2, K1, K0}
   function automatic logic [WORD_W-1:0] key_word(input logic [4*WORD_W-1:0]  key,
                                                  input logic [ROUND_IDX_W-1:0] j);
      logic [WORD_W-1:0] k [4];
      logic [1:0]        j_next;
      logic [WORD_W-1:0] mix;
      logic [WORD_W-1:0] offset;
      k[0]   = key[WORD_W-1:0];
      k[1]   = key[2*WORD_W-1:WORD_W];
      k[2]   = key[3*WORD_W-1:2*WORD_W];
      k[3]   = key[4*WORD_W-1:3*WORD_W];
      j_next = 2'(j[1:0] + 2'd1);
      mix    = k[j[1:0]] ^ rotl(k[j_next], 5'(j) + 5'd5);
      offset = 32'((32'(j) + 32'd1) * GOLDEN);
      return 32'(mix + offset);
   endfunction

   function automatic logic [WORD_W-1:0] round_fn(input logic [WORD_W-1:0] r,
                                                  input key_sched_type     rk);
      logic [WORD_W-1:0] d;
      logic [WORD_W-1:0] e;
      d = rotl(r, 5'(rk.cnst[2:0]) + 5'd7);
      e = rotr(rk.key, 5'(rk.cnst[1:0]) + 5'd11);
      d = 32'((32'(rk.key + r) ^ d) + (e ^ rk.cnst));
      return d ^ rotl(d, 5'd13);
   endfunction

endpackage

### sv/feistel_block_cipher_64_unit.sv
// Top level: 64-bit Feistel block cipher, one round per pipeline stage.
//
// Usage:
//  - req_* carries a block (word_left, word_right) in; rsp_* returns the
//    ciphered pair (out_left, out_right). Both are valid/ready channels; a
//    transfer happens on a rising edge with valid and ready both high.
//  - csr_* writes the key (index 0: key words 0/1, index 1: key words 2/3)
//    and the direction (index 2: 0 = rounds ascending, 1 = descending).
//    Index 3 is ignored. Write only while no block is in flight.
//  - A block enters the input register on the req transfer edge, then passes
//    through one register per round; the last one is the result register.
//  - Throughput: one block per cycle while rsp_ready stays high, set by the per-round stage registers.
//  - Each stage has its own ready, so bubbles close up and req_ready stays
//    high while a finished result waits, until every stage holds a block.
//  - A receiver stall holds rsp_data stable; the pipeline fills behind it.
//  - Reset (synchronous) empties the pipeline, clears the key to zero and
//    sets the direction to descending. The per-round keys are recomputed
//    into registers on the same edge as any key or direction write.
module feistel_block_cipher_64_unit #(
   parameter int ROUNDS = fbc64_pkg::ROUNDS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  fbc64_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output fbc64_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [fbc64_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fbc64_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [fbc64_pkg::CSR_DATA_W-1:0] key_low_ff;
   logic [fbc64_pkg::CSR_DATA_W-1:0] key_low_in;
   logic [fbc64_pkg::CSR_DATA_W-1:0] key_high_ff;
   logic [fbc64_pkg::CSR_DATA_W-1:0] key_high_in;
   logic                             dir_ff;
   logic                             dir_in;

   fbc64_pkg::key_sched_type key_sched_ff [ROUNDS];
   fbc64_pkg::key_sched_type key_sched_in [ROUNDS];

   logic                 in_valid_ff;
   logic                 in_valid_in;
   fbc64_pkg::block_type in_block_ff;
   fbc64_pkg::block_type in_block_in;

   logic                 stage_valid [ROUNDS+1];
   logic                 stage_ready [ROUNDS+1];
   fbc64_pkg::block_type stage_data  [ROUNDS+1];
   logic [ROUNDS:0]      valid_vec;

   // configuration registers; next values fold in reset so the round keys
   // below always track them
   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      dir_in      = dir_ff;
      if (reset) begin
         key_low_in  = '0;
         key_high_in = '0;
         dir_in      = fbc64_pkg::DIRECTION_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            fbc64_pkg::CSR_KEY_LOW:   key_low_in  = csr_wdata;
            fbc64_pkg::CSR_KEY_HIGH:  key_high_in = csr_wdata;
            fbc64_pkg::CSR_DIRECTION: dir_in      = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      key_low_ff  <= key_low_in;
      key_high_ff <= key_high_in;
      dir_ff      <= dir_in;
   end

   // per-stage key word and round constant, chosen by direction
   for (genvar i = 0; i < ROUNDS; i++) begin : g_key
      localparam logic [fbc64_pkg::ROUND_IDX_W-1:0] IDX_UP   =
         fbc64_pkg::ROUND_IDX_W'(i);
      localparam logic [fbc64_pkg::ROUND_IDX_W-1:0] IDX_DOWN =
         fbc64_pkg::ROUND_IDX_W'(ROUNDS - 1 - i);
      logic [fbc64_pkg::ROUND_IDX_W-1:0] j;

      assign j = dir_in ? IDX_DOWN : IDX_UP;

      always_comb begin
         key_sched_in[i].key  = fbc64_pkg::key_word({key_high_in, key_low_in}, j);
         key_sched_in[i].cnst = fbc64_pkg::ROUND_CONST[j];
      end

      always_ff @(posedge clock) begin
         key_sched_ff[i] <= key_sched_in[i];
      end
   end

   // input register
   assign req_ready = !in_valid_ff || stage_ready[0];

   always_comb begin
      in_valid_in = in_valid_ff;
      in_block_in = in_block_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      if (req_ready && req_valid) begin
         in_block_in.a = req_data.word_left;
         in_block_in.b = req_data.word_right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_block_ff <= in_block_in;
   end

   assign stage_valid[0] = in_valid_ff;
   assign stage_data[0]  = in_block_ff;

   for (genvar i = 0; i < ROUNDS; i++) begin : g_round
      fbc64_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_data   (stage_data[i]),
         .rk        (key_sched_ff[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   // last round register is the result register; halves leave swapped
   assign stage_ready[ROUNDS] = rsp_ready;
   assign rsp_valid           = stage_valid[ROUNDS];
   assign rsp_data.out_left   = stage_data[ROUNDS].b;
   assign rsp_data.out_right  = stage_data[ROUNDS].a;

   for (genvar i = 0; i <= ROUNDS; i++) begin : g_vvec
      assign valid_vec[i] = stage_valid[i];
   end

   // input backs up only when every register holds a block
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&valid_vec))
      else $error("req_ready low with an empty pipeline register");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> (valid_vec == '0))
      else $error("pipeline holds a block right after reset");

   a_keys_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_wr_en |=> (key_sched_ff[0] == $past(key_sched_ff[0])) &&
                     (key_sched_ff[ROUNDS-1] == $past(key_sched_ff[ROUNDS-1])))
      else $error("round keys changed without a configuration write");

endmodule

### sv/fbc64_stage.sv
// One Feistel round with its pipeline register and per-stage flow control.
module fbc64_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  fbc64_pkg::block_type   in_data,
   input  fbc64_pkg::key_sched_type rk,
   output logic                   out_valid,
   input  logic                   out_ready,
   output fbc64_pkg::block_type   out_data
);

   logic                 valid_ff;
   logic                 valid_in;
   fbc64_pkg::block_type data_ff;
   fbc64_pkg::block_type data_in;

   // stage takes a new block when empty or when its block moves on
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
      if (in_ready && in_valid) begin
         data_in.a = in_data.b;
         data_in.b = in_data.a ^ fbc64_pkg::round_fn(in_data.b, rk);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
